// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every rising edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// implication checked on every rising edge outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// shared constants and types of the raster to tile converter
// ----------------------------------------------------------------------------
`default_nettype none

package rtt_pkg;

	localparam int PIX_W               = 8;
	localparam int NIB_W               = 4;
	localparam int WORD_W              = 32;
	localparam int STORE_ROWS          = 7;
	localparam int WIDTH_REG_W         = 7;
	localparam int HEIGHT_REG_W        = 11;
	localparam int CFG_DATA_W          = 11;
	localparam int MAX_HEIGHT_TILES    = 1024;
	localparam int BAND_W              = 10;
	localparam int DEF_MAX_WIDTH_TILES = 64;
	localparam int OUT_TDATA_W         = 40;

	localparam logic [2:0] LAST_ROW  = 3'd7;
	localparam logic [2:0] LAST_NIB  = 3'd7;

	typedef enum logic [0:0] {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_reg_t;

	// tile hand-off from the packer to the emitter
	typedef struct packed {
		logic valid;
		logic image_last;
	} rtt_job_t;

endpackage

`default_nettype wire

// File: rtl/rtt_band_store.sv
// ----------------------------------------------------------------------------
// rtt_band_store
// row store for rows 0..6 of the current band, one write and one read port
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_band_store
	import rtt_pkg::*;
#(
	parameter int MAX_WIDTH_TILES = DEF_MAX_WIDTH_TILES,
	localparam int TILE_W = (MAX_WIDTH_TILES > 1) ? $clog2(MAX_WIDTH_TILES) : 1
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [2:0]        wr_row,
	input  wire logic [TILE_W-1:0] wr_tile,
	input  wire logic [WORD_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [2:0]        rd_row,
	input  wire logic [TILE_W-1:0] rd_tile,
	output logic      [WORD_W-1:0] rd_data
);

	localparam int DEPTH  = STORE_ROWS * MAX_WIDTH_TILES;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;

	// entry = row * max width + tile
	assign waddr = ADDR_W'(wr_row) * ADDR_W'(MAX_WIDTH_TILES) + ADDR_W'(wr_tile);
	assign raddr = ADDR_W'(rd_row) * ADDR_W'(MAX_WIDTH_TILES) + ADDR_W'(rd_tile);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[waddr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[raddr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

// File: rtl/rtt_packer.sv
// ----------------------------------------------------------------------------
// rtt_packer
// nibble packing, raster position counters and configuration registers
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_packer
	import rtt_pkg::*;
#(
	parameter int MAX_WIDTH_TILES = DEF_MAX_WIDTH_TILES,
	localparam int TILE_W = (MAX_WIDTH_TILES > 1) ? $clog2(MAX_WIDTH_TILES) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  pix_valid,
	output logic                       pix_ready,
	input  wire logic [PIX_W-1:0]      pixel,
	input  wire logic                  emit_busy,
	output logic                       wr_en,
	output logic      [2:0]            wr_row,
	output logic      [TILE_W-1:0]     tile,
	output logic      [WORD_W-1:0]     word,
	output rtt_job_t                   job
);

	localparam int CMP_W = ((TILE_W > WIDTH_REG_W) ? TILE_W : WIDTH_REG_W) + 1;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [WORD_W-1:0]       pack_q;
	logic [2:0]              nib_q;
	logic [TILE_W-1:0]       tile_q;
	logic [2:0]              band_row_q;
	logic [BAND_W-1:0]       band_q;

	logic [CMP_W-1:0]        w_ext;
	logic [CMP_W-1:0]        eff_w;
	logic [HEIGHT_REG_W-1:0] eff_h;
	logic                    accept;
	logic                    word_done;
	logic                    row_end;
	logic                    band_last;
	logic [WORD_W-1:0]       new_word;

	always_comb begin
		w_ext = CMP_W'(width_q);
		if (w_ext == '0) begin
			eff_w = CMP_W'(1);
		end else if (w_ext > CMP_W'(MAX_WIDTH_TILES)) begin
			eff_w = CMP_W'(MAX_WIDTH_TILES);
		end else begin
			eff_w = w_ext;
		end
		if (height_q == '0) begin
			eff_h = HEIGHT_REG_W'(1);
		end else if (height_q > HEIGHT_REG_W'(MAX_HEIGHT_TILES)) begin
			eff_h = HEIGHT_REG_W'(MAX_HEIGHT_TILES);
		end else begin
			eff_h = height_q;
		end
	end

	assign word_done = (nib_q == LAST_NIB);
	// hold off a completing pixel while the emitter still owns the store
	assign pix_ready = !(emit_busy && word_done);
	assign accept    = pix_valid && pix_ready;
	assign row_end   = CMP_W'(tile_q) >= (eff_w - CMP_W'(1));
	assign band_last = HEIGHT_REG_W'(band_q) >= (eff_h - HEIGHT_REG_W'(1));
	assign new_word  = {pack_q[WORD_W-NIB_W-1:0], pixel[NIB_W-1:0]};

	assign wr_en          = accept && word_done && (band_row_q != LAST_ROW);
	assign wr_row         = band_row_q;
	assign tile           = tile_q;
	assign word           = new_word;
	assign job.valid      = accept && word_done && (band_row_q == LAST_ROW);
	assign job.image_last = row_end && band_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_REG_W'(1);
			height_q <= HEIGHT_REG_W'(1);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pack_q     <= '0;
			nib_q      <= '0;
			tile_q     <= '0;
			band_row_q <= '0;
			band_q     <= '0;
		end else if (accept) begin
			if (!word_done) begin
				pack_q <= new_word;
				nib_q  <= nib_q + 3'd1;
			end else begin
				pack_q <= '0;
				nib_q  <= '0;
				if (row_end) begin
					tile_q <= '0;
					if (band_row_q == LAST_ROW) begin
						band_row_q <= '0;
						band_q     <= band_last ? '0 : band_q + BAND_W'(1);
					end else begin
						band_row_q <= band_row_q + 3'd1;
					end
				end else begin
					tile_q <= tile_q + TILE_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rtt_emitter.sv
// ----------------------------------------------------------------------------
// rtt_emitter
// reads a finished tile's rows back from the store and drives the output
// ----------------------------------------------------------------------------
`default_nettype none

module rtt_emitter
	import rtt_pkg::*;
#(
	parameter int MAX_WIDTH_TILES = DEF_MAX_WIDTH_TILES,
	localparam int TILE_W = (MAX_WIDTH_TILES > 1) ? $clog2(MAX_WIDTH_TILES) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire rtt_job_t          job,
	input  wire logic [TILE_W-1:0] job_tile,
	input  wire logic [WORD_W-1:0] job_word,
	output logic                   busy,
	output logic                   rd_en,
	output logic      [2:0]        rd_row,
	output logic      [TILE_W-1:0] rd_tile,
	input  wire logic [WORD_W-1:0] rd_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [WORD_W-1:0] row_word,
	output logic      [2:0]        row_num,
	output logic                   tile_last,
	output logic                   image_last
);

	logic              busy_q;
	logic [TILE_W-1:0] tile_q;
	logic [WORD_W-1:0] word_q;
	logic              ilast_q;
	logic [3:0]        issue_q;
	logic              valid_s1;
	logic [2:0]        row_s1;
	logic              out_valid_q;
	logic [WORD_W-1:0] row_word_q;
	logic [2:0]        row_num_q;
	logic              tile_last_q;
	logic              image_last_q;

	logic              out_free;
	logic              take_s1;
	logic              can_issue;

	assign out_free  = !out_valid_q || out_ready;
	assign take_s1   = valid_s1 && out_free;
	assign can_issue = busy_q && !issue_q[3] && (!valid_s1 || take_s1);
	assign rd_en     = can_issue && (issue_q[2:0] != LAST_ROW);
	assign rd_row    = issue_q[2:0];
	assign rd_tile   = tile_q;
	assign busy      = busy_q;

	// job registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			issue_q <= '0;
		end else begin
			if (job.valid) begin
				busy_q  <= 1'b1;
				issue_q <= '0;
			end else begin
				if (take_s1 && (row_s1 == LAST_ROW)) begin
					busy_q <= 1'b0;
				end
				if (can_issue) begin
					issue_q <= issue_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job.valid) begin
			tile_q  <= job_tile;
			word_q  <= job_word;
			ilast_q <= job.image_last;
		end
	end

	// stage 1: store read data (or row 7 word) waiting for the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (can_issue) begin
			valid_s1 <= 1'b1;
		end else if (take_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_issue) begin
			row_s1 <= issue_q[2:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			row_word_q   <= (row_s1 == LAST_ROW) ? word_q : rd_data;
			row_num_q    <= row_s1;
			tile_last_q  <= (row_s1 == LAST_ROW);
			image_last_q <= (row_s1 == LAST_ROW) && ilast_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_word   = row_word_q;
	assign row_num    = row_num_q;
	assign tile_last  = tile_last_q;
	assign image_last = image_last_q;

	`include "assert_macros.svh"

	`ASSERT_IMPLY(a_job_only_when_idle, clk, arst_n, job.valid, !busy_q)
	`ASSERT_NEXT(a_busy_until_last_row, clk, arst_n, take_s1 && (row_s1 != LAST_ROW), busy_q)
	`ASSERT_IMPLY(a_s1_within_job, clk, arst_n, !busy_q, !valid_s1)

endmodule

`default_nettype wire

// File: rtl/raster_to_tile_4bpp_converter.sv
// path: a tile's first row word passes the job registers, stage 1 and the output register
// throughput: one pixel per cycle, except that a word's completing pixel waits
// while the emitter is still reading back the previous tile
// output backpressure stalls pixel intake only at word boundaries
// reset: arst_n clears counters, config (width 1, height 1) and valid flags;
// the row store is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// raster_to_tile_4bpp_converter
// raster 8-bit pixels in, 8x8 4bpp tile row words out
// ----------------------------------------------------------------------------
`default_nettype none

module raster_to_tile_4bpp_converter
	import rtt_pkg::*;
#(
	parameter int MAX_WIDTH_TILES = DEF_MAX_WIDTH_TILES
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic                   cfg_index,    // 0 width_tiles, 1 height_tiles
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	// pixel stream in
	input  wire logic                   s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire logic [PIX_W-1:0]       s_axis_tdata, // [7:0] pixel
	// tile row stream out
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic      [OUT_TDATA_W-1:0] m_axis_tdata, // [31:0] row_word, [34:32] row_num
	output logic                        m_axis_tlast, // tile_last
	output logic                        m_axis_tuser  // [0] image_last
);

	localparam int TILE_W = (MAX_WIDTH_TILES > 1) ? $clog2(MAX_WIDTH_TILES) : 1;

	// packer to store / emitter
	logic              st_wr_en;
	logic [2:0]        st_wr_row;
	logic [TILE_W-1:0] cur_tile;
	logic [WORD_W-1:0] cur_word;
	rtt_job_t          job;
	logic              emit_busy;

	// emitter read port
	logic              st_rd_en;
	logic [2:0]        st_rd_row;
	logic [TILE_W-1:0] st_rd_tile;
	logic [WORD_W-1:0] st_rd_data;

	// result fields
	logic [WORD_W-1:0] row_word;
	logic [2:0]        row_num;

	// nibble packing and raster counters; rows 0..6 are written to the store,
	// a completed row 7 word becomes a tile request to the emitter
	rtt_packer #(
		.MAX_WIDTH_TILES(MAX_WIDTH_TILES)
	) u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (s_axis_tvalid),
		.pix_ready (s_axis_tready),
		.pixel     (s_axis_tdata),
		.emit_busy (emit_busy),
		.wr_en     (st_wr_en),
		.wr_row    (st_wr_row),
		.tile      (cur_tile),
		.word      (cur_word),
		.job       (job)
	);

	// band row store, 7 x max width words
	rtt_band_store #(
		.MAX_WIDTH_TILES(MAX_WIDTH_TILES)
	) u_store (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_row  (st_wr_row),
		.wr_tile (cur_tile),
		.wr_data (cur_word),
		.rd_en   (st_rd_en),
		.rd_row  (st_rd_row),
		.rd_tile (st_rd_tile),
		.rd_data (st_rd_data)
	);

	// reads rows 0..6 back, appends the row 7 word, registers the output
	rtt_emitter #(
		.MAX_WIDTH_TILES(MAX_WIDTH_TILES)
	) u_emitter (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (job),
		.job_tile   (cur_tile),
		.job_word   (cur_word),
		.busy       (emit_busy),
		.rd_en      (st_rd_en),
		.rd_row     (st_rd_row),
		.rd_tile    (st_rd_tile),
		.rd_data    (st_rd_data),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.row_word   (row_word),
		.row_num    (row_num),
		.tile_last  (m_axis_tlast),
		.image_last (m_axis_tuser)
	);

	// pack result fields, zero pad to whole bytes
	assign m_axis_tdata = {(OUT_TDATA_W - WORD_W - 3)'(0), row_num, row_word};

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// raster to tile converter testbench
// streams raster pixels under random source gaps and sink stalls, predicts
// every tile row word with a behavioral copy of the packer and row store, and
// compares each word as it leaves; registers change only at band boundaries
// ----------------------------------------------------------------------------

module testbench;
	import rtt_pkg::*;

	// one predicted tile row word
	typedef struct packed {
		logic [WORD_W-1:0] row_word;
		logic [2:0]        row_num;
		logic              tile_last;
		logic              image_last;
	} row_result_t;

	localparam int STORE_DEPTH = STORE_ROWS * DEF_MAX_WIDTH_TILES;
	localparam int DRAIN_LIMIT = 20000; // cycles allowed for the final drain
	localparam int SETTLE      = 8;     // covers the emitter pipeline with margin

	// idle draw limits for the source gap and the sink stall
	localparam int unsigned TX_GAP_MAX   = 3;
	localparam int unsigned RX_STALL_MAX = 3;

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	cfg_reg_t               cfg_index = CFG_WIDTH;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [PIX_W-1:0]       s_axis_tdata  = '0;  // [7:0] pixel
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [31:0] row_word, [34:32] row_num
	logic                   m_axis_tlast;        // tile_last
	logic                   m_axis_tuser;        // [0] image_last

	raster_to_tile_4bpp_converter uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 8 ns period
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// shadow of the block: registers, packer, row store and counters
	// ------------------------------------------------------------------------
	logic [WIDTH_REG_W-1:0]  width_reg  = 7'd1;
	logic [HEIGHT_REG_W-1:0] height_reg = 11'd1;
	logic [WORD_W-1:0]       row_store [STORE_DEPTH];
	logic [WORD_W-1:0]       shift_word = '0;
	int unsigned             column     = 0;  // pixel position within the row
	int unsigned             band_row   = 0;  // row within the band
	int unsigned             band_idx   = 0;  // band within the image

	row_result_t words_due[$];        // words still owed by the block
	logic [7:0]  pending_pixels[$];  // pixels waiting for the source side
	int unsigned error_count    = 0;

	// zero counts as one, anything past the store width saturates
	function automatic int unsigned active_width();
		if (width_reg == 0)
			return 1;
		if (width_reg > DEF_MAX_WIDTH_TILES)
			return DEF_MAX_WIDTH_TILES;
		return width_reg;
	endfunction

	function automatic int unsigned active_height();
		if (height_reg == 0)
			return 1;
		if (height_reg > MAX_HEIGHT_TILES)
			return MAX_HEIGHT_TILES;
		return height_reg;
	endfunction

	// take one pixel; on row 7 of a band a finished word releases a whole tile
	function automatic void pack_pixel(input logic [PIX_W-1:0] pix);
		int unsigned w;
		int unsigned h;
		int unsigned tile;
		bit          row_end;
		row_result_t word;
		w = active_width();
		h = active_height();
		shift_word = {shift_word[WORD_W-NIB_W-1:0], pix[NIB_W-1:0]};
		if (column[2:0] != LAST_NIB) begin
			column++;
			return;
		end
		tile    = column >> 3;
		row_end = (tile >= w - 1);
		if (band_row < STORE_ROWS) begin
			row_store[band_row * DEF_MAX_WIDTH_TILES + tile] = shift_word;
		end else begin
			for (int r = 0; r < STORE_ROWS; r++) begin
				word.row_word   = row_store[r * DEF_MAX_WIDTH_TILES + tile];
				word.row_num    = 3'(r);
				word.tile_last  = 1'b0;
				word.image_last = 1'b0;
				words_due.push_back(word);
			end
			word.row_word   = shift_word;
			word.row_num    = LAST_ROW;
			word.tile_last  = 1'b1;
			word.image_last = row_end && (band_idx >= h - 1);
			words_due.push_back(word);
		end
		shift_word = '0;
		if (row_end) begin
			column = 0;
			if (band_row >= STORE_ROWS) begin
				band_row = 0;
				band_idx = (band_idx >= h - 1) ? 0 : band_idx + 1;
			end else begin
				band_row++;
			end
		end else begin
			column++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// pixel source: one request per accepted pixel, random gap after each
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : pixel_source
		int unsigned gap_left;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			gap_left      = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				pack_pixel(s_axis_tdata);
			// slot is free when nothing is offered or the offer was just taken
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (pending_pixels.size() > 0) begin
					s_axis_tdata  <= pending_pixels.pop_front();
					s_axis_tvalid <= 1'b1;
					gap_left      = $urandom_range(0, TX_GAP_MAX);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// word sink: checks each accepted word against the oldest one owed
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : word_sink
		int unsigned stall_left;
		int unsigned hold;
		row_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_left    = 0;
		end else begin
			hold = stall_left;
			if (m_axis_tvalid && m_axis_tready) begin
				if (words_due.size() == 0) begin
					$error("unexpected row word %h (row_num %0d)",
						m_axis_tdata[WORD_W-1:0], m_axis_tdata[WORD_W+2:WORD_W]);
					error_count++;
				end else begin
					want = words_due.pop_front();
					if (m_axis_tdata[WORD_W-1:0] !== want.row_word) begin
						$error("row_word: expected %h, got %h",
							want.row_word, m_axis_tdata[WORD_W-1:0]);
						error_count++;
					end
					if (m_axis_tdata[WORD_W+2:WORD_W] !== want.row_num) begin
						$error("row_num: expected %0d, got %0d",
							want.row_num, m_axis_tdata[WORD_W+2:WORD_W]);
						error_count++;
					end
					if (m_axis_tlast !== want.tile_last) begin
						$error("tile_last: expected %b, got %b",
							want.tile_last, m_axis_tlast);
						error_count++;
					end
					if (m_axis_tuser !== want.image_last) begin
						$error("image_last: expected %b, got %b",
							want.image_last, m_axis_tuser);
						error_count++;
					end
				end
				hold = $urandom_range(0, RX_STALL_MAX);
			end
			if (hold > 0) begin
				m_axis_tready <= 1'b0;
				stall_left    = hold - 1;
			end else begin
				m_axis_tready <= 1'b1;
				stall_left    = 0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------

	// register write while the block is idle; the shadow follows at once
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		if (idx == CFG_WIDTH)
			width_reg = value[WIDTH_REG_W-1:0];
		else
			height_reg = value[HEIGHT_REG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// one full 8-row band at the current width; patterned or random pixels
	task automatic queue_band(input bit patterned);
		logic [7:0] corner_pix [8] = '{8'h00, 8'hFF, 8'h0F, 8'hF0,
		                               8'h5A, 8'hA5, 8'h01, 8'h80};
		int unsigned count;
		count = 64 * active_width();
		for (int unsigned i = 0; i < count; i++) begin
			if (patterned)
				pending_pixels.push_back(corner_pix[(i + i / 8) % 8]);
			else
				pending_pixels.push_back(8'($urandom_range(0, 255)));
		end
	endtask

	// sender holds off until the last word is out and the pipeline is quiet
	task automatic wait_idle();
		while (pending_pixels.size() != 0 || s_axis_tvalid || words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin : sequence_main
		int unsigned drain;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset values: one tile, one band, image ends on the first tile
		queue_band(1'b1);
		wait_idle();

		// zero registers count as one; upper data bits of the width write ignored
		write_reg(CFG_WIDTH, 11'h780);
		write_reg(CFG_HEIGHT, 11'h000);
		queue_band(1'b1);
		wait_idle();

		// two tiles per row, height saturates to 1024 bands
		write_reg(CFG_WIDTH, 11'h702);
		write_reg(CFG_HEIGHT, 11'h7FF);
		queue_band(1'b0);
		wait_idle();

		// height cut mid-image: band counter is already past the new last band
		write_reg(CFG_WIDTH, 11'd1);
		write_reg(CFG_HEIGHT, 11'd1);
		queue_band(1'b0);
		wait_idle();

		// final drain, bounded so a missing word shows up as a failure
		drain = 0;
		while ((pending_pixels.size() != 0 || s_axis_tvalid || words_due.size() != 0)
				&& drain < DRAIN_LIMIT) begin
			@(negedge clk);
			drain++;
		end
		repeat (SETTLE) @(posedge clk);
		if (words_due.size() != 0) begin
			$error("%0d row words never arrived", words_due.size());
			error_count++;
		end

		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/rtt_pkg.sv
rtl/rtt_band_store.sv
rtl/rtt_packer.sv
rtl/rtt_emitter.sv
rtl/raster_to_tile_4bpp_converter.sv
tb/testbench.sv
